// File: hdl/ialu_pkg.sv
// Shared opcode, kind and pipeline control definitions for the integer ALU.
`default_nettype none
package ialu_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_REM = 4'd4,
    OP_NEG = 4'd5,
    OP_EQ  = 4'd6,
    OP_NE  = 4'd7,
    OP_LT  = 4'd8,
    OP_LE  = 4'd9,
    OP_GT  = 4'd10,
    OP_GE  = 4'd11,
    OP_AND = 4'd12,
    OP_OR  = 4'd13,
    OP_NOT = 4'd14,
    OP_BAD = 4'd15
  } op_e;

  localparam logic [1:0] KIND_INT  = 2'd0;
  localparam logic [1:0] KIND_BOOL = 2'd1;

  // Control that travels with an operation down the pipeline.
  typedef struct packed {
    op_e  op;
    logic err;
    logic is_bool;
    logic neg_q;
    logic neg_r;
    logic div0;
    logic ovf;
  } ctrl_t;

endpackage
`default_nettype wire

// File: hdl/ialu_front.sv
// Decode, operand checks, simple results, divider setup and split multiplier.
`default_nettype none
module ialu_front #(
  parameter int unsigned W = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic [3:0]           req_type_i,
  input  wire logic [63:0]          a_value_i,
  input  wire logic [63:0]          b_value_i,
  input  wire logic [1:0]           a_kind_i,
  input  wire logic [1:0]           b_kind_i,
  output logic                      valid_o,
  output ialu_pkg::ctrl_t           ctrl_o,
  output logic [W-1:0]              res_o,
  output logic [W-1:0]              num_o,
  output logic [W-1:0]              den_o
);
  import ialu_pkg::*;

  localparam int unsigned LW = W / 2;
  localparam int unsigned HW = W - LW;

  logic [W-1:0]    a, b, amin, abs_a, abs_b, simple;
  logic            unary, need_bool, ok_a, ok_b, bool_op;
  logic [1:0]      need;
  op_e             op;
  ctrl_t           ctrl_d, ctrl1_q;
  logic [W-1:0]    res1_q, abs_a_q, abs_b_q;
  logic [2*LW-1:0] pp_ll_d, pp_ll_q;
  logic [HW-1:0]   pp_x1_d, pp_x1_q, pp_x2_d, pp_x2_q;
  logic            valid1_q;
  logic [HW-1:0]   cross_sum;
  logic [W-1:0]    prod;

  always_comb begin
    op        = op_e'(req_type_i);
    a         = a_value_i[W-1:0];
    b         = b_value_i[W-1:0];
    amin      = {1'b1, {(W-1){1'b0}}};
    unary     = (op == OP_NEG) || (op == OP_NOT);
    need_bool = (op == OP_AND) || (op == OP_OR) || (op == OP_NOT) ||
                (((op == OP_EQ) || (op == OP_NE)) && (a_kind_i == KIND_BOOL));
    need      = need_bool ? KIND_BOOL : KIND_INT;
    ok_a      = (a_kind_i == need) &&
                (!need_bool || a == W'(1) || a == '0);
    ok_b      = unary || ((b_kind_i == need) &&
                (!need_bool || b == W'(1) || b == '0));
    abs_a     = a[W-1] ? (W'(0) - a) : a;
    abs_b     = b[W-1] ? (W'(0) - b) : b;
    bool_op   = 1'b1;
    simple    = '0;
    unique case (op)
      OP_ADD:  begin simple = a + b;      bool_op = 1'b0; end
      OP_SUB:  begin simple = a - b;      bool_op = 1'b0; end
      OP_NEG:  begin simple = W'(0) - a;  bool_op = 1'b0; end
      OP_MUL, OP_DIV, OP_REM: bool_op = 1'b0;
      OP_EQ:   simple = W'(a == b);
      OP_NE:   simple = W'(a != b);
      OP_LT:   simple = W'($signed(a) <  $signed(b));
      OP_LE:   simple = W'($signed(a) <= $signed(b));
      OP_GT:   simple = W'($signed(a) >  $signed(b));
      OP_GE:   simple = W'($signed(a) >= $signed(b));
      OP_AND:  simple = W'((a != '0) && (b != '0));
      OP_OR:   simple = W'((a != '0) || (b != '0));
      OP_NOT:  simple = W'(a == '0);
      default: bool_op = 1'b0;
    endcase
    ctrl_d.op      = op;
    ctrl_d.err     = (op == OP_BAD) || !ok_a || !ok_b;
    ctrl_d.is_bool = bool_op;
    ctrl_d.neg_q   = a[W-1] ^ b[W-1];
    ctrl_d.neg_r   = a[W-1];
    ctrl_d.div0    = (b == '0);
    ctrl_d.ovf     = (a == amin) && (b == '1);
    // Low W bits of the product from three half-width partial products.
    pp_ll_d = a[LW-1:0] * b[LW-1:0];
    pp_x1_d = HW'(a[LW-1:0] * b[W-1:LW]);
    pp_x2_d = HW'(a[W-1:LW] * b[LW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid_o  <= valid1_q;
    end
  end

  always_comb begin
    cross_sum = pp_x1_q + pp_x2_q;
    prod      = W'(pp_ll_q) + {cross_sum, {LW{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    ctrl1_q <= ctrl_d;
    res1_q  <= simple;
    abs_a_q <= abs_a;
    abs_b_q <= abs_b;
    pp_ll_q <= pp_ll_d;
    pp_x1_q <= pp_x1_d;
    pp_x2_q <= pp_x2_d;
    ctrl_o  <= ctrl1_q;
    res_o   <= (ctrl1_q.op == OP_MUL) ? prod : res1_q;
    num_o   <= abs_a_q;
    den_o   <= abs_b_q;
  end

endmodule
`default_nettype wire

// File: hdl/ialu_div_cell.sv
// One restoring division step; the cells form a chain that yields one quotient bit each.
`default_nettype none
module ialu_div_cell #(
  parameter int unsigned W = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  ialu_pkg::ctrl_t      ctrl_i,
  input  wire logic [W-1:0]    res_i,
  input  wire logic [W-1:0]    rem_i,
  input  wire logic [W-1:0]    num_i,
  input  wire logic [W-1:0]    den_i,
  output logic                 valid_o,
  output ialu_pkg::ctrl_t      ctrl_o,
  output logic [W-1:0]         res_o,
  output logic [W-1:0]         rem_o,
  output logic [W-1:0]         num_o,
  output logic [W-1:0]         den_o
);
  import ialu_pkg::*;

  logic [W:0] trial, diff;
  logic       ge;

  always_comb begin
    trial = {rem_i, num_i[W-1]};
    diff  = trial - {1'b0, den_i};
    ge    = !diff[W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_o <= ctrl_i;
    res_o  <= res_i;
    den_o  <= den_i;
    rem_o  <= ge ? diff[W-1:0] : trial[W-1:0];
    num_o  <= {num_i[W-2:0], ge};
  end

endmodule
`default_nettype wire

// File: hdl/ialu_back.sv
// Sign correction of quotient and remainder and final result register.
`default_nettype none
module ialu_back #(
  parameter int unsigned W = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  ialu_pkg::ctrl_t      ctrl_i,
  input  wire logic [W-1:0]    res_i,
  input  wire logic [W-1:0]    rem_i,
  input  wire logic [W-1:0]    quo_i,
  output logic                 done_o,
  output logic [63:0]          result_value_o,
  output logic                 result_is_bool_o,
  output logic                 status_o
);
  import ialu_pkg::*;

  logic [W-1:0] val, qv, rv;

  always_comb begin
    qv = ctrl_i.neg_q ? (W'(0) - quo_i) : quo_i;
    rv = ctrl_i.neg_r ? (W'(0) - rem_i) : rem_i;
    priority if (ctrl_i.err) begin
      val = '0;
    end else if (ctrl_i.op == OP_DIV) begin
      val = ctrl_i.div0 ? '0 : (ctrl_i.ovf ? {1'b1, {(W-1){1'b0}}} : qv);
    end else if (ctrl_i.op == OP_REM) begin
      val = (ctrl_i.div0 || ctrl_i.ovf) ? '0 : rv;
    end else begin
      val = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_value_o   <= 64'($signed(val));
    result_is_bool_o <= ctrl_i.is_bool && !ctrl_i.err;
    status_o         <= ctrl_i.err;
  end

endmodule
`default_nettype wire

// File: hdl/int64_alu_with_safe_division_core.sv
// Top level of the pipelined signed integer ALU with safe division.
`default_nettype none
// The core takes one operation in every clock cycle: busy_o is never raised,
// so each start_i pulse is a transfer. Every operation gives exactly one
// result, shown for one cycle with done_o, in the order the operations came
// in. Each operation passes two setup stages (the multiplier is split into
// half-width partial products there), the division chain with one cell per
// quotient bit, and one output register. All operations travel the same
// chain, so order is kept. The receiver cannot stall the core and must take
// each result when done_o is high. A type error gives status 1 with a zero
// value.
module int64_alu_with_safe_division_core #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [3:0]  req_type_i,
  input  wire logic [63:0] a_value_i,
  input  wire logic [63:0] b_value_i,
  input  wire logic [1:0]  a_kind_i,
  input  wire logic [1:0]  b_kind_i,
  output logic             done_o,
  output logic [63:0]      result_value_o,
  output logic             result_is_bool_o,
  output logic             status_o
);
  import ialu_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  // Stage signals: index 0 is the chain input, index W its output.
  logic         vld   [W+1];
  ctrl_t        ctrl  [W+1];
  logic [W-1:0] res   [W+1];
  logic [W-1:0] rem   [W+1];
  logic [W-1:0] num   [W+1];
  logic [W-1:0] den   [W+1];

  // The pipeline never stalls, so a new transfer is always taken.
  assign busy_o = 1'b0;
  assign rem[0] = '0;

  ialu_front #(.W(W)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i && !busy_o),
    .req_type_i (req_type_i),
    .a_value_i  (a_value_i),
    .b_value_i  (b_value_i),
    .a_kind_i   (a_kind_i),
    .b_kind_i   (b_kind_i),
    .valid_o    (vld[0]),
    .ctrl_o     (ctrl[0]),
    .res_o      (res[0]),
    .num_o      (num[0]),
    .den_o      (den[0])
  );

  // One division cell per quotient bit, most significant bit first.
  for (genvar i = 0; i < W; i++) begin : g_cell
    ialu_div_cell #(.W(W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .ctrl_i  (ctrl[i]),
      .res_i   (res[i]),
      .rem_i   (rem[i]),
      .num_i   (num[i]),
      .den_i   (den[i]),
      .valid_o (vld[i+1]),
      .ctrl_o  (ctrl[i+1]),
      .res_o   (res[i+1]),
      .rem_o   (rem[i+1]),
      .num_o   (num[i+1]),
      .den_o   (den[i+1])
    );
  end

  ialu_back #(.W(W)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (vld[W]),
    .ctrl_i           (ctrl[W]),
    .res_i            (res[W]),
    .rem_i            (rem[W]),
    .quo_i            (num[W]),
    .done_o           (done_o),
    .result_value_o   (result_value_o),
    .result_is_bool_o (result_is_bool_o),
    .status_o         (status_o)
  );

  // A type error never comes with a nonzero value or a boolean flag.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> (result_value_o == '0) && !result_is_bool_o)
    else $error("error result carries data");

  // Boolean results are always 0 or 1.
  a_bool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_is_bool_o |-> (result_value_o[63:1] == '0))
    else $error("boolean result out of range");

  // The chain keeps one result per transfer, leaving at the chain end.
  a_chain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[W] |=> done_o)
    else $error("chain output lost");

  // The core never holds off a transfer.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("core busy");

endmodule
`default_nettype wire
